@@ hdl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, character codes and the character-to-sextet map for the
// base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Character codes
    localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;  // 'Z'
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;  // 'z'
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;  // '0'
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;  // '9'
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;  // '_'

    // Sextet values and offsets
    localparam logic [5:0] SEXTET_62     = 6'd62;
    localparam logic [5:0] SEXTET_63     = 6'd63;
    localparam logic [5:0] OFFSET_LOWER  = 6'd26;
    localparam logic [5:0] OFFSET_DIGIT  = 6'd52;

    // Group position of the last character of a group
    localparam logic [1:0] POS_LAST = 2'd3;

    // Sextet lookup result
    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } b64d_sextet_t;

    // Completed group handed from the gatherer to the byte emitter
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  count;  // bytes to emit, 1 to 3
        logic        error;
    } b64d_group_t;

    // Map one character of either alphabet to its 6-bit value
    function automatic b64d_sextet_t sextet_of(input logic [7:0] c);
        b64d_sextet_t r;
        logic [7:0]   d;
        r.ok    = 1'b1;
        r.value = '0;
        d       = '0;
        case (c) inside
            [CHAR_UPPER_A:CHAR_UPPER_Z]:
            begin
                d       = c - CHAR_UPPER_A;
                r.value = d[5:0];
            end
            [CHAR_LOWER_A:CHAR_LOWER_Z]:
            begin
                d       = c - CHAR_LOWER_A;
                r.value = d[5:0] + OFFSET_LOWER;
            end
            [CHAR_DIGIT_0:CHAR_DIGIT_9]:
            begin
                d       = c - CHAR_DIGIT_0;
                r.value = d[5:0] + OFFSET_DIGIT;
            end
            CHAR_PLUS, CHAR_MINUS:
            begin
                r.value = SEXTET_62;
            end
            CHAR_SLASH, CHAR_UNDER:
            begin
                r.value = SEXTET_63;
            end
            default:
            begin
                r.ok = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

@@ hdl/b64d_gather.sv @@
// ----------------------------------------------------------------------------
// b64d_gather
// Decodes one character per beat, gathers sextets of a four-character group
// and hands the completed 24-bit group, byte count and error flag onward.
// ----------------------------------------------------------------------------
module b64d_gather
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_ready,
    input  logic [7:0]          text_char,
    output logic                grp_valid,
    input  logic                grp_ready,
    output b64d_pkg::b64d_group_t grp
);
    import b64d_pkg::*;

    logic [1:0]   pos_reg,  pos_next;
    logic [17:0]  bits_reg, bits_next;
    logic [1:0]   pad_reg,  pad_next;
    logic         err_reg,  err_next;
    logic         accept;
    logic         is_pad;
    logic         err_char;
    logic [5:0]   sextet;
    logic [1:0]   pads;
    b64d_sextet_t lookup;

    // Stall only on the closing character while the emitter is full
    assign char_ready = (pos_reg != POS_LAST) || grp_ready;
    assign accept     = char_valid && char_ready;
    assign grp_valid  = char_valid && (pos_reg == POS_LAST);

    // Decode the character and work out the error and pad updates
    always_comb
    begin
        lookup   = sextet_of(text_char);
        is_pad   = (text_char == CHAR_PAD);
        sextet   = is_pad ? 6'd0 : lookup.value;
        pad_next = pad_reg;
        err_char = 1'b0;
        if (is_pad)
        begin
            if (pos_reg[1])
                pad_next = pad_reg + 2'd1;
            else
                err_char = 1'b1;
        end
        else
        begin
            if (!lookup.ok)
                err_char = 1'b1;
            if ((pos_reg == POS_LAST) && (pad_reg != 2'd0))
                err_char = 1'b1;
        end
        err_next = err_reg | err_char;
    end

    // Build the completed group
    always_comb
    begin
        pads      = (pad_next == 2'd3) ? 2'd2 : pad_next;
        grp.word  = {bits_reg, sextet};
        grp.count = 2'd3 - pads;
        grp.error = err_next;
    end

    // Advance the group state on each accepted beat, clear it after the last
    always_comb
    begin
        pos_next  = pos_reg;
        bits_next = bits_reg;
        if (accept)
        begin
            if (pos_reg == POS_LAST)
            begin
                pos_next  = 2'd0;
                bits_next = '0;
            end
            else
            begin
                pos_next  = pos_reg + 2'd1;
                bits_next = {bits_reg[11:0], sextet};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            bits_reg <= '0;
            pad_reg  <= '0;
            err_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            bits_reg <= bits_next;
            if (pos_reg == POS_LAST)
            begin
                pad_reg <= '0;
                err_reg <= 1'b0;
            end
            else
            begin
                pad_reg <= pad_next;
                err_reg <= err_next;
            end
        end
    end

endmodule

@@ hdl/b64d_emit.sv @@
// ----------------------------------------------------------------------------
// b64d_emit
// Holds one completed group and sends its bytes, most significant first,
// through a registered output stage, one byte per beat.
// ----------------------------------------------------------------------------
module b64d_emit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  grp_valid,
    output logic                  grp_ready,
    input  b64d_pkg::b64d_group_t grp,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            data_byte,
    output logic                  group_end,
    output logic                  bad_char
);
    import b64d_pkg::*;

    logic        held_valid_reg, held_valid_next;
    b64d_group_t held_reg;
    logic [1:0]  idx_reg,  idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        err_reg,  err_next;
    logic        load;
    logic        last_byte;
    logic        take;

    // Refill the output stage when it is empty or being drained
    assign load      = !out_valid_reg || out_ready;
    assign last_byte = (idx_reg == (held_reg.count - 2'd1));
    assign grp_ready = !held_valid_reg || (load && last_byte);
    assign take      = grp_valid && grp_ready;

    // Select the next byte of the held group
    always_comb
    begin
        case (idx_reg)
            2'd0:    byte_next = held_reg.word[23:16];
            2'd1:    byte_next = held_reg.word[15:8];
            2'd2:    byte_next = held_reg.word[7:0];
            default: byte_next = '0;
        endcase
        last_next = last_byte;
        err_next  = held_reg.error;
    end

    // Step the byte index and the hold slot
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        held_valid_next = held_valid_reg;
        idx_next        = idx_reg;
        if (load)
        begin
            out_valid_next = held_valid_reg;
            if (held_valid_reg)
            begin
                if (last_byte)
                begin
                    held_valid_next = 1'b0;
                    idx_next        = 2'd0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
        if (take)
        begin
            held_valid_next = 1'b1;
            idx_next        = 2'd0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
            held_reg <= grp;
        if (load && held_valid_reg)
        begin
            byte_reg <= byte_next;
            last_reg <= last_next;
            err_reg  <= err_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_byte = byte_reg;
    assign group_end = last_reg;
    assign bad_char  = err_reg;

endmodule

@@ hdl/base64_stream_decoder.sv @@
// Output: a completed group goes into the emitter's hold slot, then its bytes
// pass through the output register one per cycle while m_axis_tready is high.
// Throughput: one character per cycle while m_axis_tready is high, set by the
// group hold slot, which drains a group while the next group's characters arrive.
// Reset: rst_n clears the group position, gathered bits, pad count, error
// flag and all valid flags; no beat is presented until new input arrives.
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 decoder for the standard and URL-safe alphabets: one character in
// per beat, up to three bytes out per four-character group.
// ----------------------------------------------------------------------------
module base64_stream_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_char
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tlast,   // group_end
    output logic       m_axis_tuser    // [0] bad_char
);
    import b64d_pkg::*;

    logic        grp_valid;
    logic        grp_ready;
    b64d_group_t grp;

    // Decode and gather characters into groups
    b64d_gather u_gather
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (s_axis_tvalid),
        .char_ready (s_axis_tready),
        .text_char  (s_axis_tdata),
        .grp_valid  (grp_valid),
        .grp_ready  (grp_ready),
        .grp        (grp)
    );

    // Serialize group bytes onto the output stream
    b64d_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .grp_valid  (grp_valid),
        .grp_ready  (grp_ready),
        .grp        (grp),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .data_byte  (m_axis_tdata),
        .group_end  (m_axis_tlast),
        .bad_char   (m_axis_tuser)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the base64 stream decoder. Text beats go in on
// s_axis and are decoded by a behavioral model of the group logic. Every
// byte beat out of m_axis is checked field by field against the oldest
// forecast byte. The stimulus starts with a handful of hand-picked groups,
// then continues with random well-formed, padded and broken groups. Both
// sides idle at random, and the receiver holds off twice for a long stretch.
// ----------------------------------------------------------------------------
module tb;

    import b64d_pkg::*;

    localparam int RANDOM_CHARS   = 360;
    localparam int LONG_HOLD      = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // One decoded byte as it appears on m_axis
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } decoded_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // [7:0] text_char
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;        // [7:0] data_byte
    logic       m_axis_tlast;        // group_end
    logic       m_axis_tuser;        // [0] bad_char

    logic [7:0]    pending_chars[$];
    decoded_byte_t expected_bytes[$];
    int            total_chars    = 0;
    int            chars_accepted = 0;
    int            bytes_seen     = 0;
    int            mismatches     = 0;
    int            send_wait      = 0;
    int            recv_wait      = 0;
    int            hold_left      = 0;
    int            quiet_cycles   = 0;

    // Decoder model state
    logic [1:0]  grp_pos  = '0;
    logic [17:0] grp_bits = '0;
    logic [1:0]  grp_pads = '0;
    logic        grp_err  = 1'b0;

    base64_stream_decoder uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle cycles before the next beat: mostly none, otherwise drawn at random
    function automatic int draw_wait();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endfunction

    // Character for a 6-bit value, either alphabet for 62 and 63
    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        bit url;
        url = 1'($urandom_range(0, 1));
        if (v < OFFSET_LOWER)
            return CHAR_UPPER_A + v;
        if (v < OFFSET_DIGIT)
            return CHAR_LOWER_A + (v - OFFSET_LOWER);
        if (v < SEXTET_62)
            return CHAR_DIGIT_0 + (v - OFFSET_DIGIT);
        if (v == SEXTET_62)
            return url ? CHAR_MINUS : CHAR_PLUS;
        return url ? CHAR_UNDER : CHAR_SLASH;
    endfunction

    // Advance the group model by one accepted character; queue any bytes due
    function automatic void decode_char(input logic [7:0] c);
        logic [5:0]    v;
        logic          known;
        logic [23:0]   word;
        int            nbytes;
        decoded_byte_t b;
        v     = '0;
        known = 1'b1;
        if (c == CHAR_PAD)
        begin
            // padding only counts in the back half of a group
            if (grp_pos >= 2)
                grp_pads = grp_pads + 1'b1;
            else
                grp_err = 1'b1;
        end
        else
        begin
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                v = 6'(c - CHAR_UPPER_A);
            else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
                v = 6'(c - CHAR_LOWER_A) + OFFSET_LOWER;
            else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
                v = 6'(c - CHAR_DIGIT_0) + OFFSET_DIGIT;
            else if (c == CHAR_PLUS || c == CHAR_MINUS)
                v = SEXTET_62;
            else if (c == CHAR_SLASH || c == CHAR_UNDER)
                v = SEXTET_63;
            else
                known = 1'b0;
            if (!known)
                grp_err = 1'b1;
            // data following a pad in the same group
            if (grp_pos == POS_LAST && grp_pads != 0)
                grp_err = 1'b1;
        end

        if (grp_pos != POS_LAST)
        begin
            grp_bits = {grp_bits[11:0], v};
            grp_pos  = grp_pos + 1'b1;
        end
        else
        begin
            word   = {grp_bits, v};
            nbytes = 3 - ((grp_pads > 2) ? 2 : int'(grp_pads));
            for (int k = 0; k < nbytes; k++)
            begin
                b.data = word[23 - 8 * k -: 8];
                b.last = (k == nbytes - 1);
                b.bad  = grp_err;
                expected_bytes.push_back(b);
            end
            grp_pos  = '0;
            grp_bits = '0;
            grp_pads = '0;
            grp_err  = 1'b0;
        end
    endfunction

    // Stimulus and end of run
    initial
    begin
        string      directed;
        int         shape;
        logic [7:0] c;

        // plain group, all-ones bytes, one pad, pad in front half plus two
        // pads, pad at the start and data after a pad
        directed = "TWFu//__-+9=A====Z=q";
        for (int i = 0; i < directed.len(); i++)
            pending_chars.push_back(directed[i]);
        // characters outside both alphabets, at the code extremes
        pending_chars.push_back(8'h00);
        pending_chars.push_back("z");
        pending_chars.push_back(8'hFF);
        pending_chars.push_back("9");

        // random groups: mostly clean, some padded, some broken or misaligned
        total_chars = pending_chars.size() + RANDOM_CHARS;
        while (pending_chars.size() < total_chars)
        begin
            shape = $urandom_range(0, 9);
            for (int k = 0; k < 4; k++)
            begin
                c = alphabet_char(6'($urandom_range(0, 63)));
                if (shape == 7 && k == 3)
                    c = CHAR_PAD;
                if (shape == 8 && k >= 2)
                    c = CHAR_PAD;
                if (shape == 9 && $urandom_range(0, 2) == 0)
                    c = $urandom_range(0, 1) ? CHAR_PAD : 8'($urandom_range(0, 255));
                pending_chars.push_back(c);
            end
            if (shape == 6)
                pending_chars.push_back(8'($urandom_range(0, 255)));
        end
        total_chars = pending_chars.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (chars_accepted != total_chars || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Text driver: present the next character, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_wait     <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_char(s_axis_tdata);
                chars_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_wait != 0)
                begin
                    send_wait     <= send_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_chars.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_chars.pop_front();
                    // keep pushing while the receiver holds off
                    send_wait     <= (hold_left != 0) ? 0 : draw_wait();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Byte monitor: check each beat, then pace tready
    always @(posedge clk or negedge rst_n)
    begin : byte_monitor
        decoded_byte_t want;
        int            w;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait     <= 0;
            hold_left     <= 0;
        end
        else
        begin
            w = recv_wait;
            if (m_axis_tvalid && m_axis_tready)
            begin
                bytes_seen++;
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, %s %02h last %0b bad %0b",
                             $time, "actual data", m_axis_tdata, m_axis_tlast,
                             m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want.data)
                    begin
                        $display("%0t: data_byte expected %02h actual %02h",
                                 $time, want.data, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: group_end expected %0b actual %0b",
                                 $time, want.last, m_axis_tlast);
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.bad)
                    begin
                        $display("%0t: bad_char expected %0b actual %0b",
                                 $time, want.bad, m_axis_tuser);
                        mismatches++;
                    end
                end
                w = draw_wait();
            end

            if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                recv_wait     <= w;
                m_axis_tready <= 1'b0;
            end
            else if (m_axis_tvalid && m_axis_tready && (bytes_seen == 40 || bytes_seen == 220))
            begin
                // long hold so the decoder backs up into its input
                hold_left     <= LONG_HOLD;
                recv_wait     <= w;
                m_axis_tready <= 1'b0;
            end
            else if (w != 0)
            begin
                recv_wait     <= w - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                recv_wait     <= 0;
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: stop when no beat moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
